// ===== rtl/core/i2c_eeprom_access_controller_top_defines.svh =====
// Assertion macros shared by the EEPROM controller RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef I2C_EEPROM_ACCESS_CONTROLLER_TOP_DEFINES_SVH
`define I2C_EEPROM_ACCESS_CONTROLLER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define I2CEE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("i2cee check failed");

// next-cycle implication
`define I2CEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2cee check failed");

`else

`define I2CEE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define I2CEE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/i2cee_pkg.sv =====
// Shared types and codes for the I2C EEPROM controller.
// No dependencies.
package i2cee_pkg;

	// request classes after front-end decoding
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// completion status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_DEV_NACK  = 2'd1;
	localparam logic [1:0] ST_ADDR_NACK = 2'd2;
	localparam logic [1:0] ST_DATA_NACK = 2'd3;

	// which byte is on the bus
	localparam logic [1:0] K_DEVW = 2'd0;
	localparam logic [1:0] K_ADDR = 2'd1;
	localparam logic [1:0] K_DATA = 2'd2;
	localparam logic [1:0] K_DEVR = 2'd3;

	localparam int ADDR_W = 9;
	localparam int WAIT_W = 20;
	localparam int DEV_W  = 7;

	typedef struct packed {
		logic              sda_in;
		logic [7:0]        write_byte;
		logic [7:0]        byte_count;
		logic [ADDR_W-1:0] start_address;
		logic [1:0]        operation;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       done_res;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       data_request;
		logic       busy_res;
		logic       sda_release;
		logic       scl_level;
	} result_t;

	typedef struct packed {
		logic [WAIT_W-1:0] write_wait_ticks;
		logic [DEV_W-1:0]  device_address;
	} cfg_t;

endpackage

// ===== rtl/core/i2cee_front.sv =====
// Front end: accepts stream transactions, decodes the request kind and
// works out the page offset of the start address. Depends on i2cee_pkg.
module i2cee_front #(
	parameter int PAGE_BYTES = 16,
	parameter int OFF_W = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,
	input  logic [1:0]          s_tuser,
	output logic                push,
	output i2cee_pkg::item_t    push_item,
	output logic [OFF_W-1:0]    push_off,
	input  logic                fifo_full
);

	// reciprocal of PAGE_BYTES, exact quotient for 9-bit addresses
	localparam int SHIFT_Q = 18;
	localparam int RECIP   = ((1 << SHIFT_Q) + PAGE_BYTES - 1) / PAGE_BYTES;
	localparam int PROD_W  = i2cee_pkg::ADDR_W + SHIFT_Q + 1;
	localparam int REM_W   = 18;

	logic                          valid_s1;
	i2cee_pkg::item_t              item_s1;
	logic [i2cee_pkg::ADDR_W-1:0]  quot_s1;

	i2cee_pkg::item_t              item_in;
	logic [PROD_W-1:0]             prod;
	logic [REM_W-1:0]              rem;
	logic                          accept;

	always_comb begin
		item_in.start_address = s_tdata[8:0];
		item_in.byte_count    = s_tdata[16:9];
		item_in.write_byte    = s_tdata[24:17];
		item_in.sda_in        = s_tdata[25];
		if (s_tuser == i2cee_pkg::OP_WRITE || s_tuser == i2cee_pkg::OP_READ) begin
			item_in.operation = s_tuser;
		end else begin
			item_in.operation = i2cee_pkg::OP_TICK;
		end
	end

	assign prod     = PROD_W'(s_tdata[8:0]) * PROD_W'(RECIP);
	assign s_tready = !valid_s1 || !fifo_full;
	assign accept   = s_tvalid && s_tready;
	assign push     = valid_s1 && !fifo_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
			quot_s1 <= prod[SHIFT_Q +: i2cee_pkg::ADDR_W];
		end
	end

	assign rem = REM_W'(item_s1.start_address) - REM_W'(quot_s1) * REM_W'(PAGE_BYTES);
	assign push_item = item_s1;
	assign push_off  = rem[OFF_W-1:0];

endmodule

// ===== rtl/core/i2cee_fifo.sv =====
// Small register queue between the front end and the bus engine.
// No package dependencies.
module i2cee_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/core/i2cee_engine.sv =====
// Back end: bus phase state machine, one tick per queued transaction,
// with the result output register. Depends on i2cee_pkg and the defines header.
`include "i2c_eeprom_access_controller_top_defines.svh"

module i2cee_engine #(
	parameter int PAGE_BYTES = 16,
	parameter int OFF_W = 4,
	parameter int PCNT_W = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  i2cee_pkg::cfg_t     cfg,
	input  logic                fifo_empty,
	input  i2cee_pkg::item_t    item,
	input  logic [OFF_W-1:0]    item_off,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata
);

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_START1  = 4'd1;
	localparam logic [3:0] PH_START2  = 4'd2;
	localparam logic [3:0] PH_TX_LO   = 4'd3;
	localparam logic [3:0] PH_TX_HI   = 4'd4;
	localparam logic [3:0] PH_ACK_LO  = 4'd5;
	localparam logic [3:0] PH_ACK_HI  = 4'd6;
	localparam logic [3:0] PH_RSTART  = 4'd7;
	localparam logic [3:0] PH_RX_LO   = 4'd8;
	localparam logic [3:0] PH_RX_HI   = 4'd9;
	localparam logic [3:0] PH_MACK_LO = 4'd10;
	localparam logic [3:0] PH_MACK_HI = 4'd11;
	localparam logic [3:0] PH_STOP1   = 4'd12;
	localparam logic [3:0] PH_STOP2   = 4'd13;
	localparam logic [3:0] PH_STOP3   = 4'd14;
	localparam logic [3:0] PH_WAIT    = 4'd15;

	localparam int AW = i2cee_pkg::ADDR_W;
	localparam int WW = i2cee_pkg::WAIT_W;

	logic [3:0]        phase_q,   phase_d;
	logic [2:0]        bit_q,     bit_d;
	logic [7:0]        shift_q,   shift_d;
	logic [AW-1:0]     addr_q,    addr_d;
	logic [OFF_W-1:0]  off_q,     off_d;
	logic [7:0]        left_q,    left_d;
	logic [PCNT_W-1:0] pleft_q,   pleft_d;
	logic [WW-1:0]     wait_q,    wait_d;
	logic              is_read_q, is_read_d;
	logic [1:0]        kind_q,    kind_d;
	logic [1:0]        err_q,     err_d;

	i2cee_pkg::result_t res, out_q;
	logic               m_tvalid_q;

	logic              frame;
	logic [AW-1:0]     frame_addr;
	logic [OFF_W-1:0]  frame_off;
	logic [7:0]        frame_left;
	logic [8:0]        room;
	logic [AW-1:0]     addr_inc;
	logic [OFF_W-1:0]  off_inc;
	logic [7:0]        left_dec;
	logic [PCNT_W-1:0] pleft_dec;
	logic [7:0]        rx_shift;

	assign pop      = !fifo_empty && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	// address counter with its page offset kept alongside
	assign addr_inc  = addr_q + 1'b1;
	assign off_inc   = (addr_inc == '0 || off_q == OFF_W'(PAGE_BYTES - 1)) ? '0 : off_q + 1'b1;
	assign left_dec  = left_q - 1'b1;
	assign pleft_dec = (pleft_q != '0) ? pleft_q - 1'b1 : '0;
	assign rx_shift  = {shift_q[6:0], item.sda_in};

	always_comb begin
		phase_d   = phase_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		addr_d    = addr_q;
		off_d     = off_q;
		left_d    = left_q;
		pleft_d   = pleft_q;
		wait_d    = wait_q;
		is_read_d = is_read_q;
		kind_d    = kind_q;
		err_d     = err_q;
		frame      = 1'b0;
		frame_addr = addr_q;
		frame_off  = off_q;
		frame_left = left_q;
		res = '0;
		res.scl_level   = 1'b1;
		res.sda_release = 1'b1;

		case (phase_q)
			PH_IDLE: begin
				if (item.operation == i2cee_pkg::OP_WRITE ||
				    item.operation == i2cee_pkg::OP_READ) begin
					if (item.byte_count == 8'd0) begin
						res.done_res = 1'b1;
					end else begin
						is_read_d  = (item.operation == i2cee_pkg::OP_READ);
						addr_d     = item.start_address;
						off_d      = item_off;
						left_d     = item.byte_count;
						err_d      = i2cee_pkg::ST_OK;
						frame      = 1'b1;
						frame_addr = item.start_address;
						frame_off  = item_off;
						frame_left = item.byte_count;
					end
				end
			end
			PH_START1: phase_d = PH_START2;
			PH_START2: begin
				res.sda_release = 1'b0;
				phase_d = PH_TX_LO;
			end
			PH_TX_LO: begin
				if (kind_q == i2cee_pkg::K_DATA && bit_q == 3'd0) begin
					shift_d = item.write_byte;
				end
				res.scl_level   = 1'b0;
				res.sda_release = shift_d[7];
				phase_d = PH_TX_HI;
			end
			PH_TX_HI: begin
				res.sda_release = shift_q[7];
				shift_d = {shift_q[6:0], 1'b0};
				bit_d   = bit_q + 1'b1;
				phase_d = (bit_q == 3'd7) ? PH_ACK_LO : PH_TX_LO;
			end
			PH_ACK_LO: begin
				res.scl_level = 1'b0;
				phase_d = PH_ACK_HI;
			end
			PH_ACK_HI: begin
				if (item.sda_in) begin
					case (kind_q)
						i2cee_pkg::K_ADDR: err_d = i2cee_pkg::ST_ADDR_NACK;
						i2cee_pkg::K_DATA: err_d = i2cee_pkg::ST_DATA_NACK;
						default:           err_d = i2cee_pkg::ST_DEV_NACK;
					endcase
					phase_d = PH_STOP1;
				end else begin
					case (kind_q)
						i2cee_pkg::K_DEVW: begin
							shift_d = addr_q[7:0];
							kind_d  = i2cee_pkg::K_ADDR;
							phase_d = PH_TX_LO;
						end
						i2cee_pkg::K_ADDR: begin
							if (is_read_q) begin
								shift_d = {cfg.device_address | {6'd0, addr_q[8]}, 1'b1};
								kind_d  = i2cee_pkg::K_DEVR;
								phase_d = PH_RSTART;
							end else begin
								kind_d  = i2cee_pkg::K_DATA;
								res.data_request = 1'b1;
								phase_d = PH_TX_LO;
							end
						end
						i2cee_pkg::K_DATA: begin
							addr_d  = addr_inc;
							off_d   = off_inc;
							left_d  = left_dec;
							pleft_d = pleft_dec;
							if (pleft_dec == '0 || left_dec == 8'd0) begin
								phase_d = PH_STOP1;
							end else begin
								res.data_request = 1'b1;
								phase_d = PH_TX_LO;
							end
						end
						default: begin
							shift_d = 8'd0;
							phase_d = PH_RX_LO;
						end
					endcase
				end
			end
			PH_RSTART: begin
				res.scl_level = 1'b0;
				phase_d = PH_START1;
			end
			PH_RX_LO: begin
				res.scl_level = 1'b0;
				phase_d = PH_RX_HI;
			end
			PH_RX_HI: begin
				shift_d = rx_shift;
				bit_d   = bit_q + 1'b1;
				if (bit_q == 3'd7) begin
					res.read_byte  = rx_shift;
					res.read_valid = 1'b1;
					addr_d  = addr_inc;
					off_d   = off_inc;
					left_d  = left_dec;
					phase_d = PH_MACK_LO;
				end else begin
					phase_d = PH_RX_LO;
				end
			end
			PH_MACK_LO: begin
				res.scl_level   = 1'b0;
				res.sda_release = (left_q == 8'd0);
				phase_d = PH_MACK_HI;
			end
			PH_MACK_HI: begin
				res.sda_release = (left_q == 8'd0);
				phase_d = (left_q == 8'd0) ? PH_STOP1 : PH_RX_LO;
			end
			PH_STOP1: begin
				res.scl_level   = 1'b0;
				res.sda_release = 1'b0;
				phase_d = PH_STOP2;
			end
			PH_STOP2: begin
				res.sda_release = 1'b0;
				phase_d = PH_STOP3;
			end
			PH_STOP3: begin
				if (err_q != i2cee_pkg::ST_OK || is_read_q) begin
					res.done_res = 1'b1;
					res.status   = err_q;
					phase_d = PH_IDLE;
				end else begin
					wait_d  = cfg.write_wait_ticks;
					phase_d = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (wait_q != '0) begin
					wait_d = wait_q - 1'b1;
				end else if (left_q == 8'd0) begin
					res.done_res = 1'b1;
					phase_d = PH_IDLE;
				end else begin
					frame = 1'b1;
				end
			end
			default: phase_d = PH_IDLE;
		endcase

		// new page frame: size it to the page room and load the device byte
		room = 9'(PAGE_BYTES) - 9'(frame_off);
		if (frame) begin
			pleft_d = (room < {1'b0, frame_left}) ? PCNT_W'(room) : PCNT_W'(frame_left);
			shift_d = {cfg.device_address | {6'd0, frame_addr[8]}, 1'b0};
			kind_d  = i2cee_pkg::K_DEVW;
			bit_d   = 3'd0;
			phase_d = PH_START1;
		end

		res.busy_res = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bit_q      <= '0;
			shift_q    <= '0;
			addr_q     <= '0;
			off_q      <= '0;
			left_q     <= '0;
			pleft_q    <= '0;
			wait_q     <= '0;
			is_read_q  <= 1'b0;
			kind_q     <= i2cee_pkg::K_DEVW;
			err_q      <= i2cee_pkg::ST_OK;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q   <= phase_d;
				bit_q     <= bit_d;
				shift_q   <= shift_d;
				addr_q    <= addr_d;
				off_q     <= off_d;
				left_q    <= left_d;
				pleft_q   <= pleft_d;
				wait_q    <= wait_d;
				is_read_q <= is_read_d;
				kind_q    <= kind_d;
				err_q     <= err_d;
			end
			if (pop) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	`I2CEE_ASSERT_NEXT(a_pop_shows_result, clk, arst_n, pop, m_tvalid_q)
	`I2CEE_ASSERT_IMPLIES(a_idle_bit_zero, clk, arst_n, phase_q == PH_IDLE, bit_q == 3'd0)
	`I2CEE_ASSERT_IMPLIES(a_done_not_busy, clk, arst_n, m_tvalid_q && out_q.done_res, !out_q.busy_res)
	`I2CEE_ASSERT_IMPLIES(a_status_with_done, clk, arst_n, m_tvalid_q && out_q.status != i2cee_pkg::ST_OK, out_q.done_res)

endmodule

// ===== rtl/core/i2c_eeprom_access_controller_top.sv =====
// Top level of the I2C EEPROM controller: config registers and the
// front / queue / engine chain. Depends on i2cee_pkg, i2cee_front, i2cee_fifo, i2cee_engine.
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------------
//  s_*     | s_tvalid / s_tready     | one bus tick plus optional request
//  m_*     | m_tvalid / m_tready     | bus pin levels and status for that tick
//  apb     | psel, penable, pwrite   | device_address @0x0, write_wait_ticks @0x4
//
// One transaction in gives exactly one transaction out. Sustained rate is one
// transaction per clock while m_tready is high; the engine steps its phase state machine once per popped tick.
// From input to result a transaction passes the front register, the queue and the output register.
// Reset returns the engine to idle, empties the queue and sets device_address 0x50
// and write_wait_ticks 1000. A stall on m_tready holds the result; the queue then
// fills and s_tready drops. Config writes are meant only while the engine is idle.
module i2c_eeprom_access_controller_top #(
	parameter int PAGE_BYTES  = 16,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata, low bit up: start_address[8:0], byte_count[16:9], write_byte[24:17],
	// sda_in[25], zero fill [31:26]
	input  logic [31:0] s_tdata,
	// tuser: operation[1:0]
	input  logic [1:0]  s_tuser,
	// stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata, low bit up: scl_level[0], sda_release[1], busy_res[2], data_request[3],
	// read_byte[11:4], read_valid[12], done_res[13], status[15:14]
	output logic [15:0] m_tdata,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int OFF_W   = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
	localparam int PCNT_W  = $clog2(PAGE_BYTES + 1);
	localparam int ENTRY_W = $bits(i2cee_pkg::item_t) + OFF_W;

	i2cee_pkg::cfg_t  cfg_q;
	logic             cfg_wr;

	logic                 push;
	i2cee_pkg::item_t     push_item;
	logic [OFF_W-1:0]     push_off;
	logic                 pop;
	logic                 fifo_full;
	logic                 fifo_empty;
	logic [ENTRY_W-1:0]   fifo_rdata;
	i2cee_pkg::item_t     head_item;
	logic [OFF_W-1:0]     head_off;

	// config registers: paddr[2] selects the register, low bits ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address   <= 7'h50;
			cfg_q.write_wait_ticks <= 20'd1000;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				cfg_q.write_wait_ticks <= pwdata[19:0];
			end else begin
				cfg_q.device_address <= pwdata[6:0];
			end
		end
	end

	assign prdata = paddr[2] ? {12'd0, cfg_q.write_wait_ticks} : {25'd0, cfg_q.device_address};

	// front end: decode and page offset
	i2cee_front #(
		.PAGE_BYTES (PAGE_BYTES),
		.OFF_W      (OFF_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_item (push_item),
		.push_off  (push_off),
		.fifo_full (fifo_full)
	);

	// decoupling queue
	i2cee_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_off, push_item}),
		.pop    (pop),
		.rdata  (fifo_rdata),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	assign head_item = fifo_rdata[$bits(i2cee_pkg::item_t)-1:0];
	assign head_off  = fifo_rdata[ENTRY_W-1 -: OFF_W];

	// bus engine with output register
	i2cee_engine #(
		.PAGE_BYTES (PAGE_BYTES),
		.OFF_W      (OFF_W),
		.PCNT_W     (PCNT_W)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.fifo_empty (fifo_empty),
		.item       (head_item),
		.item_off   (head_off),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
